// File: hdl/wp_pkg.sv
// Watchpoint table package: operation and status codes, item and result types, back-end states.
package wp_pkg;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CHECK  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_BAD_INDEX = 3'd4
  } status_t;

  typedef struct packed {
    op_t         op;
    logic        search;
    logic [15:0] address;
    logic [4:0]  index;
    logic [15:0] data;
  } cmd_t;

  typedef struct packed {
    status_t     status;
    logic        changed;
    logic [15:0] entry_address;
    logic [15:0] value;
    logic [4:0]  entry_index;
    logic [4:0]  entries_used;
  } result_t;

  typedef struct packed {
    logic [15:0] addr;
    logic [15:0] word;
  } entry_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SEARCH,
    BK_SHIFT,
    BK_FETCH,
    BK_UPDATE,
    BK_EMIT
  } back_state_t;

endpackage

// File: hdl/wp_front.sv
// Watchpoint table front end: accepts request items and classifies them into commands.
module wp_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  logic [1:0]     operation,
  input  logic [15:0]    address,
  input  logic [4:0]     index,
  input  logic [15:0]    data,
  output logic           cmd_valid,
  input  logic           cmd_ready,
  output wp_pkg::cmd_t   cmd
);
  import wp_pkg::*;

  cmd_t cmd_next;

  assign req_ready = !cmd_valid || cmd_ready;

  always_comb begin
    cmd_next.op      = op_t'(operation);
    cmd_next.search  = (op_t'(operation) == OP_ADD) || (op_t'(operation) == OP_REMOVE);
    cmd_next.address = address;
    cmd_next.index   = index;
    cmd_next.data    = data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (req_ready) begin
      cmd_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      cmd <= cmd_next;
    end
  end

endmodule

// File: hdl/wp_queue.sv
// Watchpoint table command queue: two-entry FIFO between front end and back end.
module wp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  wp_pkg::cmd_t   push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output wp_pkg::cmd_t   pop_cmd
);
  import wp_pkg::*;

  cmd_t       slots [2];
  logic [1:0] fill;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       push;
  logic       pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_cmd    = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

// File: hdl/wp_back.sv
// Watchpoint table back end: entry memory, scan and compaction sequencer, result register.
module wp_back #(
  parameter int TABLE_DEPTH = 20
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  wp_pkg::cmd_t     cmd_in,
  output logic             out_valid,
  input  logic             out_ready,
  output wp_pkg::result_t  out_res
);
  import wp_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

  entry_t mem [TABLE_DEPTH];
  entry_t rd_data;

  back_state_t state, state_next;
  cmd_t        cmd, cmd_next;
  result_t     res, res_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] k, k_next;
  logic [IDX_W-1:0] w, w_next;
  logic             pend, pend_next;

  logic             we;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata;
  logic             re;
  logic [IDX_W-1:0] raddr;
  logic             load_out;

  logic             hit;
  logic             scan_end;
  logic             shift_done;
  logic             full;
  logic             idx_ok;
  logic             out_free;
  logic [CNT_W-1:0] hit_pos;
  logic [CMP_W-1:0] idx_ext;
  logic [CMP_W-1:0] cnt_ext;

  assign hit        = pend && (rd_data.addr == cmd.address);
  assign scan_end   = (k >= count);
  assign shift_done = scan_end && !pend;
  assign full       = (count == CNT_W'(TABLE_DEPTH));
  assign hit_pos    = k - 1'b1;
  assign idx_ext    = CMP_W'(cmd.index);
  assign cnt_ext    = CMP_W'(count);
  assign idx_ok     = (idx_ext < cnt_ext);
  assign out_free   = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (cmd_valid) begin
          state_next = cmd_in.search ? BK_SEARCH : BK_FETCH;
        end
      end
      BK_SEARCH: begin
        if (hit) begin
          state_next = (cmd.op == OP_ADD) ? BK_EMIT : BK_SHIFT;
        end else if (scan_end) begin
          state_next = BK_EMIT;
        end
      end
      BK_SHIFT: begin
        if (shift_done) begin
          state_next = BK_EMIT;
        end
      end
      BK_FETCH: begin
        state_next = idx_ok ? BK_UPDATE : BK_EMIT;
      end
      BK_UPDATE: begin
        state_next = BK_EMIT;
      end
      BK_EMIT: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_ready  = 1'b0;
    cmd_next   = cmd;
    res_next   = res;
    count_next = count;
    k_next     = k;
    w_next     = w;
    pend_next  = pend;
    we         = 1'b0;
    waddr      = w;
    wdata      = rd_data;
    re         = 1'b0;
    raddr      = k[IDX_W-1:0];
    load_out   = 1'b0;
    case (state)
      BK_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          cmd_next  = cmd_in;
          k_next    = '0;
          pend_next = 1'b0;
        end
      end
      BK_SEARCH: begin
        if (hit) begin
          pend_next = 1'b0;
          res_next  = '{ST_OK, 1'b0, 16'd0, 16'd0, 5'(hit_pos), 5'(count)};
          if (cmd.op == OP_ADD) begin
            res_next.status = ST_DUPLICATE;
          end else begin
            res_next.entries_used = 5'(count - 1'b1);
            w_next = hit_pos[IDX_W-1:0];
          end
        end else if (scan_end) begin
          pend_next = 1'b0;
          res_next  = '{ST_OK, 1'b0, 16'd0, 16'd0, 5'd0, 5'(count)};
          if (cmd.op == OP_ADD) begin
            if (full) begin
              res_next.status = ST_FULL;
            end else begin
              we         = 1'b1;
              waddr      = count[IDX_W-1:0];
              wdata      = '{cmd.address, 16'd0};
              count_next = count + 1'b1;
              res_next.entry_index  = 5'(count);
              res_next.entries_used = 5'(count + 1'b1);
            end
          end else begin
            res_next.status = ST_NOT_FOUND;
          end
        end else begin
          re        = 1'b1;
          k_next    = k + 1'b1;
          pend_next = 1'b1;
        end
      end
      BK_SHIFT: begin
        if (pend) begin
          we     = 1'b1;
          w_next = w + 1'b1;
        end
        if (!scan_end) begin
          re        = 1'b1;
          k_next    = k + 1'b1;
          pend_next = 1'b1;
        end else begin
          pend_next = 1'b0;
        end
        if (shift_done) begin
          count_next = count - 1'b1;
        end
      end
      BK_FETCH: begin
        if (idx_ok) begin
          re    = 1'b1;
          raddr = idx_ext[IDX_W-1:0];
        end else begin
          res_next = '{ST_BAD_INDEX, 1'b0, 16'd0, 16'd0, cmd.index, 5'(count)};
        end
      end
      BK_UPDATE: begin
        res_next = '{ST_OK, 1'b0, rd_data.addr, rd_data.word, cmd.index, 5'(count)};
        if (cmd.op == OP_CHECK) begin
          we               = 1'b1;
          waddr            = idx_ext[IDX_W-1:0];
          wdata            = '{rd_data.addr, cmd.data};
          res_next.changed = (rd_data.word != cmd.data);
          res_next.value   = cmd.data;
        end
      end
      BK_EMIT: begin
        load_out = out_free;
      end
      default: begin
        cmd_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd <= cmd_next;
    res <= res_next;
    k   <= k_next;
    w   <= w_next;
    if (load_out) begin
      out_res <= res;
    end
  end

endmodule

// File: hdl/watchpoint_table.sv
// Watchpoint table top level: front end, command queue and back end.
//
//   channel   direction  handshake            payload
//   request   in         req_valid/req_ready  operation, address, index, data
//   response  out        rsp_valid/rsp_ready  status, changed, entry_address, value,
//                                             entry_index, entries_used
//
// Add and remove scan one entry a cycle through the single memory read port, stopping at
// the matching entry or after the last one. Remove then compacts the later entries down by
// one place. Check and read entry fetch the indexed entry; check then writes the new word.
// An index at or beyond count goes straight to the result. A request passes the front
// register, the queue and the back-end start, and its response the result register.
// rst is synchronous; it empties the table and the queue. Entry memory has no reset.
// A stalled response holds the back end; the queue and front register take up to three more
// items before req_ready drops.
module watchpoint_table #(
  parameter int TABLE_DEPTH = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [1:0]  operation,
  input  logic [15:0] address,
  input  logic [4:0]  index,
  input  logic [15:0] data,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [2:0]  status,
  output logic        changed,
  output logic [15:0] entry_address,
  output logic [15:0] value,
  output logic [4:0]  entry_index,
  output logic [4:0]  entries_used
);
  import wp_pkg::*;

  cmd_t    front_cmd;
  cmd_t    queue_cmd;
  logic    front_valid;
  logic    front_ready;
  logic    queue_valid;
  logic    queue_ready;
  result_t rsp;

  wp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .operation (operation),
    .address   (address),
    .index     (index),
    .data      (data),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  wp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready),
    .pop_cmd    (queue_cmd)
  );

  wp_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (queue_valid),
    .cmd_ready (queue_ready),
    .cmd_in    (queue_cmd),
    .out_valid (rsp_valid),
    .out_ready (rsp_ready),
    .out_res   (rsp)
  );

  assign status        = rsp.status;
  assign changed       = rsp.changed;
  assign entry_address = rsp.entry_address;
  assign value         = rsp.value;
  assign entry_index   = rsp.entry_index;
  assign entries_used  = rsp.entries_used;

endmodule

// File: tb/watchpoint_table_checker.sv
// Watchpoint table checker: mirrors the table, predicts each result and compares it.
module watchpoint_table_checker #(
  parameter int DEPTH = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_ready,
  input  logic [1:0]  operation,
  input  logic [15:0] address,
  input  logic [4:0]  index,
  input  logic [15:0] data,
  input  logic        rsp_valid,
  input  logic        rsp_ready,
  input  logic [2:0]  status,
  input  logic        changed,
  input  logic [15:0] entry_address,
  input  logic [15:0] value,
  input  logic [4:0]  entry_index,
  input  logic [4:0]  entries_used,
  output int          errors,
  output int          pending,
  output int          results_checked,
  output int          n_duplicate,
  output int          n_full,
  output int          n_not_found,
  output int          n_bad_index
);
  import wp_pkg::*;

  logic [15:0] watch_addr [DEPTH];
  logic [15:0] seen_word  [DEPTH];
  logic [4:0]  watch_count;
  result_t     expected_results [$];
  result_t     want;

  initial begin
    errors = 0;
    pending = 0;
    results_checked = 0;
    n_duplicate = 0;
    n_full = 0;
    n_not_found = 0;
    n_bad_index = 0;
    watch_count = '0;
  end

  function automatic result_t apply_command(op_t op, logic [15:0] addr, logic [4:0] idx,
                                            logic [15:0] word);
    result_t r;
    int      hit;
    r = '0;
    r.status = ST_OK;
    hit = -1;
    if (op == OP_ADD || op == OP_REMOVE) begin
      for (int k = 0; k < watch_count; k++)
        if (hit < 0 && watch_addr[k] == addr) hit = k;
    end
    case (op)
      OP_ADD: begin
        if (hit >= 0) begin
          r.status = ST_DUPLICATE;
          r.entry_index = hit[4:0];
        end else if (watch_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          watch_addr[watch_count] = addr;
          seen_word[watch_count] = '0;
          r.entry_index = watch_count;
          watch_count = watch_count + 5'd1;
        end
      end
      OP_REMOVE: begin
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.entry_index = hit[4:0];
          for (int k = hit; k + 1 < watch_count; k++) begin
            watch_addr[k] = watch_addr[k + 1];
            seen_word[k] = seen_word[k + 1];
          end
          watch_count = watch_count - 5'd1;
        end
      end
      default: begin
        r.entry_index = idx;
        if (idx >= watch_count) begin
          r.status = ST_BAD_INDEX;
        end else if (op == OP_CHECK) begin
          r.entry_address = watch_addr[idx];
          r.changed = (seen_word[idx] != word);
          seen_word[idx] = word;
          r.value = word;
        end else begin
          r.entry_address = watch_addr[idx];
          r.value = seen_word[idx];
        end
      end
    endcase
    r.entries_used = watch_count;
    return r;
  endfunction

  task automatic compare_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_results.delete();
      watch_count = '0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: status %0d entry_index %0d entries_used %0d",
                   $time, status, entry_index, entries_used);
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          compare_field("status", want.status, status);
          compare_field("changed", want.changed, changed);
          compare_field("entry_address", want.entry_address, entry_address);
          compare_field("value", want.value, value);
          compare_field("entry_index", want.entry_index, entry_index);
          compare_field("entries_used", want.entries_used, entries_used);
        end
      end
      if (req_valid && req_ready) begin
        want = apply_command(op_t'(operation), address, index, data);
        case (want.status)
          ST_DUPLICATE: n_duplicate++;
          ST_FULL:      n_full++;
          ST_NOT_FOUND: n_not_found++;
          ST_BAD_INDEX: n_bad_index++;
          default: ;
        endcase
        expected_results.push_back(want);
      end
    end
    pending = expected_results.size();
  end

endmodule

// File: tb/tb_watchpoint_table.sv
// Watchpoint table testbench top: clock, reset, stimulus, response stalls and verdict.
module tb_watchpoint_table;
  import wp_pkg::*;

  localparam int DEPTH      = 20;
  localparam int POOL_SIZE  = 26;
  localparam int QUIET_MAX  = 3000;

  logic        clk;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  logic [1:0]  operation = OP_ADD;
  logic [15:0] address = '0;
  logic [4:0]  index = '0;
  logic [15:0] data = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  logic [2:0]  status;
  logic        changed;
  logic [15:0] entry_address;
  logic [15:0] value;
  logic [4:0]  entry_index;
  logic [4:0]  entries_used;

  int          errors, pending, results_checked;
  int          n_duplicate, n_full, n_not_found, n_bad_index;
  int          send_idle = 0;
  int          rsp_stall = 0;
  int          quiet_cycles = 0;
  int          items_sent = 0;
  logic [15:0] addr_pool [POOL_SIZE];

  watchpoint_table #(.TABLE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready),
    .operation(operation), .address(address), .index(index), .data(data),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
    .status(status), .changed(changed), .entry_address(entry_address),
    .value(value), .entry_index(entry_index), .entries_used(entries_used)
  );

  watchpoint_table_checker #(.DEPTH(DEPTH)) u_checker (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready),
    .operation(operation), .address(address), .index(index), .data(data),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
    .status(status), .changed(changed), .entry_address(entry_address),
    .value(value), .entry_index(entry_index), .entries_used(entries_used),
    .errors(errors), .pending(pending), .results_checked(results_checked),
    .n_duplicate(n_duplicate), .n_full(n_full), .n_not_found(n_not_found),
    .n_bad_index(n_bad_index)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(negedge clk) begin
    rsp_ready <= ($urandom_range(0, 99) >= rsp_stall);
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("timeout: nothing accepted for %0d cycles, %0d results outstanding",
               QUIET_MAX, pending);
      $display("watchpoint_table test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called just after a falling edge; returns just after a falling edge once the item is accepted
  task automatic send_item(op_t op, logic [15:0] addr, logic [4:0] idx, logic [15:0] word);
    while ($urandom_range(0, 99) < send_idle) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    operation <= op;
    address <= addr;
    index <= idx;
    data <= word;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_address();
    if ($urandom_range(0, 99) < 85) return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic logic [15:0] pick_word();
    logic [15:0] fixed [4];
    fixed[0] = 16'h0000;
    fixed[1] = 16'hFFFF;
    fixed[2] = 16'h5A5A;
    fixed[3] = 16'hA5A5;
    if ($urandom_range(0, 1) == 0) return fixed[$urandom_range(0, 3)];
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  task automatic random_items(int count, int add_pct, int remove_pct);
    int   roll;
    op_t  op;
    logic [4:0] idx;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < add_pct) op = OP_ADD;
      else if (roll < add_pct + remove_pct) op = OP_REMOVE;
      else if (roll < add_pct + remove_pct + (100 - add_pct - remove_pct) / 2) op = OP_CHECK;
      else op = OP_READ;
      if ($urandom_range(0, 99) < 80) idx = 5'($urandom_range(0, DEPTH));
      else idx = 5'($urandom_range(0, 31));
      send_item(op, pick_address(), idx, pick_word());
    end
  endtask

  initial begin
    addr_pool[0] = 16'h0000;
    addr_pool[1] = 16'hFFFF;
    for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = 16'($urandom_range(0, 16'hFFFF));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // fill to capacity with extreme and distinct addresses, then try full, duplicate, check, read and remove
    send_item(OP_ADD, 16'h0000, 5'd0, 16'h0000);
    send_item(OP_ADD, 16'hFFFF, 5'd0, 16'hFFFF);
    for (int i = 1; i <= DEPTH - 2; i++) send_item(OP_ADD, 16'(16'h0101 * i), 5'd0, 16'h0000);
    send_item(OP_ADD, 16'h8000, 5'd31, 16'hFFFF);
    send_item(OP_ADD, 16'hFFFF, 5'd0, 16'h0000);
    send_item(OP_CHECK, 16'h0000, 5'd19, 16'hFFFF);
    send_item(OP_CHECK, 16'hFFFF, 5'd19, 16'hFFFF);
    send_item(OP_CHECK, 16'h0000, 5'd1, 16'h0000);
    // removing entry 0 shifts the word checked above down to entry 18
    send_item(OP_REMOVE, 16'h0000, 5'd0, 16'h0000);
    send_item(OP_READ, 16'h0000, 5'd18, 16'h0000);
    send_item(OP_READ, 16'hFFFF, 5'd31, 16'hFFFF);
    send_item(OP_CHECK, 16'h0000, 5'd19, 16'h1234);
    send_item(OP_REMOVE, 16'h0000, 5'd0, 16'h0000);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  rsp_stall = 0;  end
        1: begin send_idle = 51; rsp_stall = 0;  end
        2: begin send_idle = 0;  rsp_stall = 51; end
        default: begin send_idle = 27; rsp_stall = 27; end
      endcase
      random_items(50, 50, 15);
      random_items(50, 15, 50);
    end

    req_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("ran %0d items under four idle/stall mixes, %0d results checked",
             items_sent, results_checked);
    $display("errors seen: duplicate %0d, table full %0d, not found %0d, bad index %0d",
             n_duplicate, n_full, n_not_found, n_bad_index);
    if (errors == 0) begin
      $display("watchpoint_table test passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("watchpoint_table test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/wp_pkg.sv
hdl/wp_front.sv
hdl/wp_queue.sv
hdl/wp_back.sv
hdl/watchpoint_table.sv
tb/watchpoint_table_checker.sv
tb/tb_watchpoint_table.sv
